[hw/rtl/memory_slot_binding_table_unit_macros.svh]
// Assertion macros for the slot binding table.
// Included by files that carry concurrent checks; relies on clk and arst_n in scope.
`ifndef MEMORY_SLOT_BINDING_TABLE_UNIT_MACROS_SVH
`define MEMORY_SLOT_BINDING_TABLE_UNIT_MACROS_SVH

`ifndef SYNTH
// check sampled on clk, masked while reset is asserted
`define MSBT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check sampled on clk, also active during reset
`define MSBT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSBT_ASSERT(lbl, prop, msg)
`define MSBT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[hw/rtl/msbt_pkg.sv]
// Shared constants, codes and types for the slot binding table.
// No dependencies; imported by msbt_key_cam and memory_slot_binding_table_unit.
package msbt_pkg;

	localparam int SLOT_COUNT = 64;
	localparam int KEY_BITS   = 32;

	localparam int SLOT_W  = $clog2(SLOT_COUNT);
	localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
	localparam int KEY_W   = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int HANDLE_W = 32;
	localparam int SIDX_W  = 8;
	localparam int OSLOT_W = 6;

	typedef enum logic [1:0] {
		CMD_BIND  = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_FETCH = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_INVALID   = 2'd3
	} status_t;

	// write request into the key store
	typedef struct packed {
		logic              en;
		logic              set;   // 1 bind, 0 unbind
		logic [SLOT_W-1:0] idx;
		logic [KEY_W-1:0]  key;
	} cam_wr_t;

	// lookup answer from the key store
	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] idx;
	} cam_hit_t;

endpackage

[hw/rtl/msbt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Old data is returned on a read-during-write to the same address.
module msbt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/msbt_key_cam.sv]
// Key store with per-entry present bits and a parallel match over all slots.
// Depends on msbt_pkg and the assertion macro header.
`include "memory_slot_binding_table_unit_macros.svh"

module msbt_key_cam
	import msbt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [KEY_W-1:0] lookup_key,
	input  cam_wr_t          wr,
	output cam_hit_t         res
);

	logic [KEY_W-1:0]      key_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] present_q;
	logic [SLOT_COUNT-1:0] match;

	always_ff @(posedge clk) begin
		if (wr.en && wr.set) begin
			key_q[wr.idx] <= wr.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
		end else if (wr.en) begin
			present_q[wr.idx] <= wr.set;
		end
	end

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			match[i] = present_q[i] && (key_q[i] == lookup_key);
		end
	end

	// keys are unique among bound slots, so an OR encoder suffices
	always_comb begin
		res.hit = |match;
		res.idx = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (match[i]) begin
				res.idx = res.idx | SLOT_W'(i);
			end
		end
	end

	`MSBT_ASSERT(a_unique_key, $onehot0(match), "key bound to more than one slot")
	`MSBT_ASSERT(a_bind_sets, (wr.en && wr.set) |=> present_q[$past(wr.idx)], "bind lost")
	`MSBT_ASSERT(a_unbind_clr, (wr.en && !wr.set) |=> !present_q[$past(wr.idx)], "unbind lost")

endmodule

[hw/rtl/memory_slot_binding_table_unit.sv]
// Slot binding table: binds keys to slots, frees them, fetches stored handles.
// Input transfer to result: input register, then result register.
// One item per cycle unless m_tready stalls; the parallel key search is combinational.
// Reset (arst_n low): all slots unbound, free stack empty, batch flag clear.
// No clearing pass; stores are only read where a bound/present bit vouches for them.
// Depends on msbt_pkg, msbt_key_cam, msbt_ram and the assertion macro header.
`include "memory_slot_binding_table_unit_macros.svh"

module memory_slot_binding_table_unit
	import msbt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // key[31:0], handle[63:32], handle_valid[64],
	                              // slot_index[72:65], zero[79:73]
	input  logic [1:0]  s_tuser,  // command[1:0]
	input  logic        s_tlast,  // last_in_batch
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // slot[5:0], status[7:6], newly_bound[8],
	                              // out_handle[40:9], batch_ok[41], zero[47:42]
);

	// ---------------------------------------------------------------
	// Input register
	// ---------------------------------------------------------------
	logic                valid_s1;
	logic [1:0]          cmd_s1;
	logic [KEY_W-1:0]    key_s1;
	logic [HANDLE_W-1:0] handle_s1;
	logic                hvalid_s1;
	logic [SIDX_W-1:0]   sidx_s1;
	logic                last_s1;

	logic load;     // transfer into the input register
	logic advance;  // input register item retires into the result register
	logic out_valid_q;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign load     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_s1    <= s_tuser;
			key_s1    <= s_tdata[KEY_W-1:0];
			handle_s1 <= s_tdata[63:32];
			hvalid_s1 <= s_tdata[64];
			sidx_s1   <= s_tdata[72:65];
			last_s1   <= s_tlast;
		end
	end

	// ---------------------------------------------------------------
	// Table state
	// ---------------------------------------------------------------
	logic [CNT_W-1:0]      free_depth_q;
	logic [CNT_W-1:0]      used_q;       // slots handed out at least once
	logic                  batch_fail_q;
	logic [SLOT_COUNT-1:0] hpres_q;      // handle present per slot

	cam_wr_t  cam_wr;
	cam_hit_t cam_res;

	msbt_key_cam u_cam (
		.clk        (clk),
		.arst_n     (arst_n),
		.lookup_key (key_s1),
		.wr         (cam_wr),
		.res        (cam_res)
	);

	// handle store: read address follows the item entering (or held in) s1
	logic                h_we;
	logic [SLOT_W-1:0]   h_waddr;
	logic [HANDLE_W-1:0] h_wdata;
	logic [SLOT_W-1:0]   h_raddr;
	logic [HANDLE_W-1:0] h_rdata;
	logic                h_byp_q;
	logic [HANDLE_W-1:0] h_byp_data_q;
	logic [HANDLE_W-1:0] h_val;

	assign h_raddr = load ? s_tdata[65 +: SLOT_W] : sidx_s1[SLOT_W-1:0];

	msbt_ram #(
		.WIDTH (HANDLE_W),
		.DEPTH (SLOT_COUNT)
	) u_handle_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	// free stack: read address tracks the next top of stack; fs_top holds the top entry
	logic              fs_we;
	logic [SLOT_W-1:0] fs_waddr;
	logic [SLOT_W-1:0] fs_wdata;
	logic [SLOT_W-1:0] fs_raddr;
	logic [SLOT_W-1:0] fs_rdata;
	logic              fs_byp_q;
	logic [SLOT_W-1:0] fs_byp_data_q;
	logic [SLOT_W-1:0] fs_top;
	logic [CNT_W-1:0]  depth_nxt;
	logic [CNT_W-1:0]  top_ptr;

	assign top_ptr  = depth_nxt - CNT_W'(1);
	assign fs_raddr = top_ptr[SLOT_W-1:0];

	msbt_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (SLOT_COUNT)
	) u_free_ram (
		.clk   (clk),
		.we    (fs_we),
		.waddr (fs_waddr),
		.wdata (fs_wdata),
		.raddr (fs_raddr),
		.rdata (fs_rdata)
	);

	// same-edge writes are not seen by the RAM read; forward them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_byp_q  <= 1'b0;
			fs_byp_q <= 1'b0;
		end else begin
			h_byp_q  <= h_we && (h_waddr == h_raddr);
			fs_byp_q <= fs_we && (fs_waddr == fs_raddr);
		end
	end

	always_ff @(posedge clk) begin
		h_byp_data_q  <= h_wdata;
		fs_byp_data_q <= fs_wdata;
	end

	assign h_val  = h_byp_q ? h_byp_data_q : h_rdata;
	assign fs_top = fs_byp_q ? fs_byp_data_q : fs_rdata;

	// ---------------------------------------------------------------
	// Command decode and state update for the item in s1
	// ---------------------------------------------------------------
	logic [SLOT_W-1:0]   r_slot;
	status_t             r_status;
	logic                r_newly;
	logic [HANDLE_W-1:0] r_handle;
	logic                r_bok;
	logic [CNT_W-1:0]    used_nxt;
	logic                bfail_nxt;
	logic                hp_we;
	logic                hp_val;
	logic                sidx_ok;

	assign sidx_ok = ({1'b0, sidx_s1} < (SIDX_W + 1)'(SLOT_COUNT))
		&& hpres_q[sidx_s1[SLOT_W-1:0]];

	always_comb begin
		r_slot    = '0;
		r_status  = ST_OK;
		r_newly   = 1'b0;
		r_handle  = '0;
		r_bok     = 1'b0;
		depth_nxt = free_depth_q;
		used_nxt  = used_q;
		bfail_nxt = batch_fail_q;
		cam_wr    = '{en: 1'b0, set: 1'b0, idx: '0, key: key_s1};
		h_we      = 1'b0;
		h_waddr   = '0;
		h_wdata   = handle_s1;
		hp_we     = 1'b0;
		hp_val    = hvalid_s1;
		fs_we     = 1'b0;
		fs_waddr  = free_depth_q[SLOT_W-1:0];
		fs_wdata  = cam_res.idx;

		case (cmd_s1)
			CMD_BIND: begin
				if (cam_res.hit) begin
					r_slot = cam_res.idx;
				end else begin
					// reuse the most recently freed slot first
					if (free_depth_q != '0) begin
						r_slot    = fs_top;
						r_newly   = 1'b1;
						depth_nxt = free_depth_q - CNT_W'(1);
					end else if (used_q < CNT_W'(SLOT_COUNT)) begin
						r_slot   = used_q[SLOT_W-1:0];
						r_newly  = 1'b1;
						used_nxt = used_q + CNT_W'(1);
					end else begin
						r_status = ST_FULL;
					end
					cam_wr.en  = r_newly;
					cam_wr.set = 1'b1;
					cam_wr.idx = r_slot;
					h_we       = r_newly;
					h_waddr    = r_slot;
					hp_we      = r_newly;
				end
			end
			CMD_FREE: begin
				if (!cam_res.hit) begin
					r_status = ST_NOT_FOUND;
				end else begin
					r_slot     = cam_res.idx;
					cam_wr.en  = 1'b1;
					cam_wr.idx = cam_res.idx;
					h_we       = 1'b1;
					h_waddr    = cam_res.idx;
					h_wdata    = '0;
					hp_we      = 1'b1;
					hp_val     = 1'b0;
					if (free_depth_q < CNT_W'(SLOT_COUNT)) begin
						fs_we     = 1'b1;
						depth_nxt = free_depth_q + CNT_W'(1);
					end
				end
			end
			CMD_FETCH: begin
				if (sidx_ok) begin
					r_handle = h_val;
				end else begin
					r_status  = ST_INVALID;
					bfail_nxt = 1'b1;
				end
				if (last_s1) begin
					r_bok     = !bfail_nxt;
					bfail_nxt = 1'b0;
				end
			end
			default: begin
				r_status = ST_INVALID;
			end
		endcase

		// nothing commits unless the item retires this cycle
		if (!advance) begin
			depth_nxt = free_depth_q;
			used_nxt  = used_q;
			bfail_nxt = batch_fail_q;
			cam_wr.en = 1'b0;
			h_we      = 1'b0;
			hp_we     = 1'b0;
			fs_we     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_depth_q <= '0;
			used_q       <= '0;
			batch_fail_q <= 1'b0;
			hpres_q      <= '0;
		end else begin
			free_depth_q <= depth_nxt;
			used_q       <= used_nxt;
			batch_fail_q <= bfail_nxt;
			if (hp_we) begin
				hpres_q[h_waddr] <= hp_val;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	logic [OSLOT_W-1:0]  res_slot_q;
	status_t             res_status_q;
	logic                res_newly_q;
	logic [HANDLE_W-1:0] res_handle_q;
	logic                res_bok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_slot_q   <= OSLOT_W'(r_slot);
			res_status_q <= r_status;
			res_newly_q  <= r_newly;
			res_handle_q <= r_handle;
			res_bok_q    <= r_bok;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, res_bok_q, res_handle_q, res_newly_q, res_status_q, res_slot_q};

	`MSBT_ASSERT(a_depth_le_used, free_depth_q <= used_q, "free stack deeper than slots used")
	`MSBT_ASSERT(a_full_only_when_exhausted,
		(advance && r_status == ST_FULL) |-> (free_depth_q == '0
		&& used_q == CNT_W'(SLOT_COUNT)), "table full reported with slots left")
	`MSBT_ASSERT(a_stall_has_item, !s_tready |-> (valid_s1 && out_valid_q),
		"input stalled without a pending result")

endmodule
